>>> src/swaa_pkg.sv
// shared types and constants for the sliding-window averager
// no dependencies

package swaa_pkg;

   // fixed field widths of the result item and the coefficient
   localparam int AVG_BITS    = 12;
   localparam int SCALED_BITS = 36;
   localparam int COEF_BITS   = 24;

   // coefficient after reset: 1.0 in unsigned Q8.16
   localparam logic [COEF_BITS-1:0] COEF_RESET = 24'h01_0000;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_OFFSET_MODE = 1'b0,
      CSR_SCALE_COEF  = 1'b1
   } csr_index_type;

endpackage

>>> src/sliding_window_adc_averager.sv
// sliding-window averager, top level: running sum, fill tracking, config
// depends on swaa_pkg, swaa_delay_line, swaa_scaler
//
// Usage:
//  - req channel: one converter sample and the zero level per item, taken at an
//    edge where req_valid is high and req_stall is low.
//  - rsp channel: window average and scaled value (unsigned Q20.16), held while
//    rsp_stall is high.
//  - csr port: csr_index 0 is offset_mode (1 = current channel, absolute
//    difference from the zero level), 1 is scale_coef (unsigned Q8.16).
//  - the first WINDOW_LENGTH items fill the window and give no result; every
//    later item gives one result, averaged over itself and the previous
//    WINDOW_LENGTH-1 samples.
//  - each item passes the sum stage, divide stage and result register to rsp.
//  - throughput: one item per cycle while req_stall is low; the running-sum
//    register adds each new sample and drops the oldest from the cell chain.
//  - a stalled receiver holds the result register; the two stages in front
//    keep taking items until they are full, then req_stall rises.
//  - reset clears the window, the sum, the fill state and the pipeline,
//    sets offset_mode to 0 and scale_coef to 1.0.

module sliding_window_adc_averager
   import swaa_pkg::*;
#(
   parameter int WINDOW_LENGTH = 16,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic [SAMPLE_BITS-1:0] req_zero_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [AVG_BITS-1:0]    rsp_average,
   output logic [SCALED_BITS-1:0] rsp_scaled_value,
   input  logic                   csr_write,
   input  csr_index_type          csr_index,
   input  logic [COEF_BITS-1:0]   csr_wdata
);

   localparam int LOG_LEN  = $clog2(WINDOW_LENGTH);
   localparam int SUM_BITS = SAMPLE_BITS + LOG_LEN;
   localparam logic [LOG_LEN-1:0] LAST_POS = LOG_LEN'(WINDOW_LENGTH - 1);

   logic                   offset_mode_ff;
   logic [COEF_BITS-1:0]   scale_coef_ff;

   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic [SUM_BITS-1:0]    full_sum;
   logic [LOG_LEN-1:0]     pos_ff;
   logic                   filled_ff;
   logic [SAMPLE_BITS-1:0] tail_sample;

   logic                   stage_valid_ff;
   logic [SUM_BITS-1:0]    stage_sum_ff;
   logic [SAMPLE_BITS-1:0] stage_zero_ff;
   logic                   stage_ready;
   logic                   scaler_ready;
   logic                   accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_mode_ff <= 1'b0;
         scale_coef_ff  <= COEF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OFFSET_MODE: offset_mode_ff <= csr_wdata[0];
            CSR_SCALE_COEF:  scale_coef_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input handshake
   assign stage_ready = !stage_valid_ff || scaler_ready;
   assign accept      = req_valid && stage_ready;
   assign req_stall   = !stage_ready;

   // window of the previous samples
   swaa_delay_line #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_delay_line (
      .clock      (clock),
      .reset      (reset),
      .shift      (accept),
      .head_sample(req_sample),
      .tail_sample(tail_sample)
   );

   // running sum: full window now, then drop the oldest sample
   assign full_sum = sum_ff + SUM_BITS'(req_sample);
   assign sum_in   = full_sum - SUM_BITS'(tail_sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         pos_ff    <= '0;
         filled_ff <= 1'b0;
      end else if (accept) begin
         sum_ff <= sum_in;
         if (pos_ff == LAST_POS) begin
            pos_ff    <= '0;
            filled_ff <= 1'b1;
         end else begin
            pos_ff <= pos_ff + LOG_LEN'(1);
         end
      end
   end

   // sum stage: only items after the window has filled go on
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         stage_valid_ff <= accept && filled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_sum_ff  <= full_sum;
         stage_zero_ff <= req_zero_level;
      end
   end

   // average, scaling and result register
   swaa_scaler #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_scaler (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (stage_valid_ff),
      .in_ready        (scaler_ready),
      .in_sum          (stage_sum_ff),
      .in_zero         (stage_zero_ff),
      .offset_mode     (offset_mode_ff),
      .scale_coef      (scale_coef_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_scaled_value(rsp_scaled_value)
   );

endmodule

>>> src/swaa_cell.sv
// one storage cell of the sample delay line
// depends on nothing; chained by swaa_delay_line

module swaa_cell #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  logic [SAMPLE_BITS-1:0] data_in,
   output logic [SAMPLE_BITS-1:0] data_out
);

   logic [SAMPLE_BITS-1:0] sample_ff;

   // take the neighbor's sample on every accepted item, clear at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift) begin
         sample_ff <= data_in;
      end
   end

   assign data_out = sample_ff;

endmodule

>>> src/swaa_delay_line.sv
// row of swaa_cell instances holding the last WINDOW_LENGTH-1 samples
// depends on swaa_cell

module swaa_delay_line #(
   parameter int WINDOW_LENGTH = 16,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  logic [SAMPLE_BITS-1:0] head_sample,
   output logic [SAMPLE_BITS-1:0] tail_sample
);

   localparam int CELLS = WINDOW_LENGTH - 1;

   logic [SAMPLE_BITS-1:0] link [0:CELLS];

   assign link[0] = head_sample;

   // each cell hands its sample to the next one
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      swaa_cell #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .data_in (link[i]),
         .data_out(link[i+1])
      );
   end

   // oldest sample, leaving the window on the next item
   assign tail_sample = link[CELLS];

endmodule

>>> src/swaa_scaler.sv
// divide stage, then combinational scaling, feeding the result register
// depends on swaa_pkg

module swaa_scaler
   import swaa_pkg::*;
#(
   parameter int WINDOW_LENGTH = 16,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 in_valid,
   output logic                                                 in_ready,
   input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]         in_sum,
   input  logic [SAMPLE_BITS-1:0]                               in_zero,
   input  logic                                                 offset_mode,
   input  logic [COEF_BITS-1:0]                                 scale_coef,
   output logic                                                 rsp_valid,
   input  logic                                                 rsp_stall,
   output logic [AVG_BITS-1:0]                                  rsp_average,
   output logic [SCALED_BITS-1:0]                               rsp_scaled_value
);

   localparam int LOG_LEN   = $clog2(WINDOW_LENGTH);
   localparam int SUM_BITS  = SAMPLE_BITS + LOG_LEN;
   localparam int RSH       = SUM_BITS + LOG_LEN;
   localparam int MUL_BITS  = SUM_BITS + 1;
   localparam int DPROD_BITS = SUM_BITS + MUL_BITS;
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << RSH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [MUL_BITS-1:0] RECIP = RECIP_WIDE[MUL_BITS-1:0];
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

   logic                   avg_valid_ff;
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [SAMPLE_BITS-1:0] zero_ff;
   logic                   avg_ready;

   logic                   out_valid_ff;
   logic [AVG_BITS-1:0]    out_avg_ff;
   logic [SCALED_BITS-1:0] out_scaled_ff;
   logic                   out_ready;

   logic [DPROD_BITS-1:0]  div_prod;
   logic [SAMPLE_BITS-1:0] quotient;
   logic [SAMPLE_BITS-1:0] operand;
   logic [PROD_BITS-1:0]   scale_prod;
   logic [SCALED_BITS-1:0] scaled_in;

   // per-stage ready so bubbles close up while the output is stalled
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign avg_ready = !avg_valid_ff || out_ready;
   assign in_ready  = avg_ready;

   // sum divided by the window length: reciprocal multiply, exact for every sum
   always_comb begin
      div_prod = DPROD_BITS'(in_sum) * DPROD_BITS'(RECIP);
      quotient = div_prod[RSH +: SAMPLE_BITS];
   end

   // divide stage
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else if (avg_ready) begin
         avg_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (avg_ready && in_valid) begin
         avg_ff  <= quotient;
         zero_ff <= in_zero;
      end
   end

   // operand: average, or its distance from the zero level in current mode
   always_comb begin
      if (offset_mode) begin
         operand = (avg_ff >= zero_ff) ? (avg_ff - zero_ff) : (zero_ff - avg_ff);
      end else begin
         operand = avg_ff;
      end
      scale_prod = PROD_BITS'(operand) * PROD_BITS'(scale_coef);
   end

   // fit the product into the Q20.16 result, saturating if it cannot
   if (PROD_BITS > SCALED_BITS) begin : g_sat
      assign scaled_in = (|scale_prod[PROD_BITS-1:SCALED_BITS]) ? '1
                       : scale_prod[SCALED_BITS-1:0];
   end else begin : g_nosat
      assign scaled_in = SCALED_BITS'(scale_prod);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= avg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && avg_valid_ff) begin
         out_avg_ff    <= AVG_BITS'(avg_ff);
         out_scaled_ff <= scaled_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_average      = out_avg_ff;
   assign rsp_scaled_value = out_scaled_ff;

endmodule
